FILE: hw/rtl/sest_pkg.sv
// Shared types and constants for the scored entry table with stable sort.
package sest_pkg;

    localparam int MOVE_W     = 16;
    localparam int SCORE_W    = 16;
    localparam int ACT_W      = 3;
    localparam int NUM_W      = 9;
    localparam int STATUS_W   = 2;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Action codes carried by an input transaction.
    localparam logic [ACT_W-1:0] ACT_CLEAR      = 3'd0;
    localparam logic [ACT_W-1:0] ACT_APPEND     = 3'd1;
    localparam logic [ACT_W-1:0] ACT_PROMOTE    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_SORT       = 3'd3;
    localparam logic [ACT_W-1:0] ACT_STORE_PREV = 3'd4;
    localparam logic [ACT_W-1:0] ACT_UPDATE     = 3'd5;
    localparam logic [ACT_W-1:0] ACT_READ       = 3'd6;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // Register index of the initial score register.
    localparam logic REG_INIT_SCORE = 1'b0;
    localparam logic signed [SCORE_W-1:0] INIT_SCORE_RESET = -16'sd32000;

    // Operations broadcast to every cell of the chain.
    localparam logic [2:0] CELL_HOLD    = 3'd0;
    localparam logic [2:0] CELL_APPEND  = 3'd1;
    localparam logic [2:0] CELL_UPDATE  = 3'd2;
    localparam logic [2:0] CELL_COPY    = 3'd3;
    localparam logic [2:0] CELL_ROTATE  = 3'd4;
    localparam logic [2:0] CELL_PROMOTE = 3'd5;
    localparam logic [2:0] CELL_SORT    = 3'd6;

    typedef struct packed {
        logic [ACT_W-1:0]          action;
        logic [NUM_W-1:0]          entry_number;
        logic [MOVE_W-1:0]         move_word;
        logic signed [SCORE_W-1:0] new_score;
    } sest_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic [MOVE_W-1:0]         entry_move;
        logic signed [SCORE_W-1:0] entry_score;
        logic signed [SCORE_W-1:0] entry_previous;
        logic [NUM_W-1:0]          entry_count;
    } sest_out_t;

    typedef struct packed {
        logic [MOVE_W-1:0]         move;
        logic signed [SCORE_W-1:0] score;
        logic signed [SCORE_W-1:0] prev;
    } sest_entry_t;

    typedef struct packed {
        logic [2:0]                op;
        logic                      phase;
        logic [MOVE_W-1:0]         move;
        logic signed [SCORE_W-1:0] init_score;
        logic signed [SCORE_W-1:0] new_score;
    } sest_ctrl_t;

    typedef struct packed {
        logic hit;
        logic ahead;
        logic live;
        logic live_next;
        logic odd;
        logic has_left;
    } sest_sel_t;

endpackage

FILE: hw/rtl/scored_entry_table_with_stable_sort.sv
// Top level of the scored entry table: a chain of entry cells and its sequencer.
//
// The table is a row of DEPTH cells, each holding one entry (move word, current
// score, previous score); every cell can take its left or right neighbor's entry
// in a cycle. Clear, append, store-previous, update and any transaction with a
// bad entry number or a full table go from the execute state straight to the
// finish state. Read and promote first rotate the chain once around its whole
// length: entry N is captured as it passes cell zero, and after DEPTH rotations
// every entry is back in place; a promote then shifts the cells ahead of entry
// N down by one and drops the captured entry into cell zero in the same cycle.
// Sort runs DEPTH alternating even/odd compare-exchange phases between
// neighboring cells (odd-even transposition), which orders the valid entries by
// score in descending order and keeps equal scores in their original order.
// Input transactions are taken one at a time, while the previous result may
// still sit in the output register waiting to be taken. The initial score
// register lies at byte address 0 of the APB port and resets to -32000; the
// user must see that it is written only while the block is idle, which the
// block itself does not enforce. Entries that were never appended are never
// read, so the cells need no reset.
module scored_entry_table_with_stable_sort
    import sest_pkg::*;
#(
    parameter int DEPTH = 256
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  sest_in_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output sest_out_t             out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > NUM_W) ? CNT_W : NUM_W;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_ROT   = 3'd2;
    localparam logic [2:0] ST_SHIFT = 3'd3;
    localparam logic [2:0] ST_SORT  = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    logic [2:0]                state_reg;
    logic [2:0]                state_next;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic [IDX_W-1:0]          step_reg;
    logic [IDX_W-1:0]          step_next;
    logic [STATUS_W-1:0]       status_reg;
    logic [STATUS_W-1:0]       status_next;
    sest_entry_t               hold_reg;
    sest_entry_t               hold_next;
    logic signed [SCORE_W-1:0] init_reg;

    // Transaction held for the duration of its work.
    logic [ACT_W-1:0]          act_reg;
    logic [IDX_W-1:0]          pos_reg;
    logic                      ok_reg;
    logic [MOVE_W-1:0]         move_reg;
    logic signed [SCORE_W-1:0] nscore_reg;

    logic                      out_valid_reg;
    sest_out_t                 out_data_reg;

    logic                      in_accept;
    logic                      slot_free;
    logic [CMP_W-1:0]          num_ext;
    logic [CMP_W-1:0]          cnt_ext;
    logic [CMP_W-1:0]          pos_wide;
    logic                      num_ok;
    logic [CNT_W-1:0]          target;
    logic                      read_hit;
    logic [CNT_W+NUM_W-1:0]    count_wide;
    logic                      cfg_write;
    sest_ctrl_t                ctrl;
    sest_out_t                 res;
    sest_entry_t               cell_q [DEPTH];

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign slot_free = !out_valid_reg || !out_stall;

    // Entry number check against the count as it stands when the transaction
    // is accepted; the count only changes after that.
    assign num_ext  = CMP_W'(in_data.entry_number);
    assign cnt_ext  = CMP_W'(count_reg);
    assign num_ok   = (num_ext != '0) && (num_ext <= cnt_ext);
    assign pos_wide = num_ext - CMP_W'(1);

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            act_reg    <= in_data.action;
            pos_reg    <= num_ok ? pos_wide[IDX_W-1:0] : '0;
            ok_reg     <= num_ok;
            move_reg   <= in_data.move_word;
            nscore_reg <= in_data.new_score;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        step_next        = step_reg;
        status_next      = status_reg;
        hold_next        = hold_reg;
        target           = count_reg;
        ctrl.op          = CELL_HOLD;
        ctrl.phase       = step_reg[0];
        ctrl.move        = move_reg;
        ctrl.init_score  = init_reg;
        ctrl.new_score   = nscore_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                status_next = STATUS_OK;
                state_next  = ST_FIN;
                step_next   = '0;
                unique case (act_reg)
                    ACT_CLEAR:
                    begin
                        count_next = '0;
                    end
                    ACT_APPEND:
                    begin
                        if (count_reg == CNT_W'(DEPTH))
                        begin
                            status_next = STATUS_FULL;
                        end
                        else
                        begin
                            ctrl.op    = CELL_APPEND;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    ACT_PROMOTE, ACT_READ:
                    begin
                        if (ok_reg)
                        begin
                            state_next = ST_ROT;
                        end
                        else
                        begin
                            status_next = STATUS_RANGE;
                        end
                    end
                    ACT_SORT:
                    begin
                        state_next = ST_SORT;
                    end
                    ACT_STORE_PREV:
                    begin
                        ctrl.op = CELL_COPY;
                    end
                    ACT_UPDATE:
                    begin
                        if (ok_reg)
                        begin
                            ctrl.op = CELL_UPDATE;
                            target  = CNT_W'(pos_reg);
                        end
                        else
                        begin
                            status_next = STATUS_RANGE;
                        end
                    end
                    default:
                    begin
                        status_next = STATUS_OK;
                    end
                endcase
            end
            ST_ROT:
            begin
                // After step_reg rotations, cell zero holds original entry step_reg.
                ctrl.op = CELL_ROTATE;
                if (step_reg == pos_reg)
                begin
                    hold_next = cell_q[0];
                end
                step_next = step_reg + IDX_W'(1);
                if (step_reg == IDX_W'(DEPTH - 1))
                begin
                    state_next = (act_reg == ACT_PROMOTE) ? ST_SHIFT : ST_FIN;
                end
            end
            ST_SHIFT:
            begin
                ctrl.op    = CELL_PROMOTE;
                state_next = ST_FIN;
            end
            ST_SORT:
            begin
                ctrl.op   = CELL_SORT;
                step_next = step_reg + IDX_W'(1);
                if (step_reg == IDX_W'(DEPTH - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            step_reg   <= '0;
            status_reg <= STATUS_OK;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            step_reg   <= step_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

    // The chain of cells. Cell zero's left neighbor is the captured entry so
    // that a promote drops it in at the front; the last cell's right neighbor
    // is cell zero, which closes the ring used for rotation.
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            sest_sel_t   sel;
            sest_entry_t left_in;

            assign sel.hit       = (CNT_W'(gi) == target);
            assign sel.ahead     = (IDX_W'(gi) <= pos_reg);
            assign sel.live      = (CNT_W'(gi) < count_reg);
            assign sel.live_next = (CNT_W'(gi + 1) < count_reg);
            assign sel.odd       = 1'((gi % 2) != 0);
            assign sel.has_left  = (gi != 0);

            if (gi == 0)
            begin : g_first
                assign left_in = hold_reg;
            end
            else
            begin : g_rest
                assign left_in = cell_q[gi - 1];
            end

            sest_cell u_cell (
                .clk   (clk),
                .ctrl  (ctrl),
                .sel   (sel),
                .left  (left_in),
                .right (cell_q[(gi + 1) % DEPTH]),
                .q     (cell_q[gi])
            );
        end
    endgenerate

    // Result assembly. Only a successful read shows entry fields.
    assign read_hit   = (act_reg == ACT_READ) && (status_reg == STATUS_OK);
    assign count_wide = {{NUM_W{1'b0}}, count_reg};

    always_comb
    begin
        res.status         = status_reg;
        res.entry_move     = read_hit ? hold_reg.move : '0;
        res.entry_score    = read_hit ? hold_reg.score : '0;
        res.entry_previous = read_hit ? hold_reg.prev : '0;
        res.entry_count    = count_wide[NUM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == ST_FIN) && slot_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_FIN) && slot_free)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Configuration port. The register is decoded by word address; the byte
    // offset bits are not looked at.
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[APB_ADDR_W-1] == REG_INIT_SCORE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg <= INIT_SCORE_RESET;
        end
        else if (cfg_write)
        begin
            init_reg <= pwdata[SCORE_W-1:0];
        end
    end

    assign prdata = (paddr[APB_ADDR_W-1] == REG_INIT_SCORE)
                    ? {{(APB_DATA_W - SCORE_W){1'b0}}, init_reg} : '0;
    assign pready = 1'b1;

endmodule

FILE: hw/rtl/sest_cell.sv
// One cell of the entry chain: holds one entry and trades it with its neighbors.
module sest_cell
    import sest_pkg::*;
(
    input  logic        clk,
    input  sest_ctrl_t  ctrl,
    input  sest_sel_t   sel,
    input  sest_entry_t left,
    input  sest_entry_t right,
    output sest_entry_t q
);

    sest_entry_t q_reg;
    sest_entry_t q_next;
    logic        left_role;
    logic        swap;

    always_comb
    begin
        q_next    = q_reg;
        left_role = (sel.odd == ctrl.phase);
        swap      = 1'b0;
        unique case (ctrl.op)
            CELL_HOLD:
            begin
                q_next = q_reg;
            end
            CELL_APPEND:
            begin
                if (sel.hit)
                begin
                    q_next.move  = ctrl.move;
                    q_next.score = ctrl.init_score;
                    q_next.prev  = ctrl.init_score;
                end
            end
            CELL_UPDATE:
            begin
                if (sel.hit)
                begin
                    q_next.score = ctrl.new_score;
                end
            end
            CELL_COPY:
            begin
                q_next.prev = q_reg.score;
            end
            CELL_ROTATE:
            begin
                q_next = right;
            end
            CELL_PROMOTE:
            begin
                if (sel.ahead)
                begin
                    q_next = left;
                end
            end
            CELL_SORT:
            begin
                // Both cells of a pair evaluate the same strict compare, so
                // equal scores never trade places.
                if (left_role)
                begin
                    swap = sel.live_next && (q_reg.score < right.score);
                    if (swap)
                    begin
                        q_next = right;
                    end
                end
                else
                begin
                    swap = sel.has_left && sel.live && (left.score < q_reg.score);
                    if (swap)
                    begin
                        q_next = left;
                    end
                end
            end
            default:
            begin
                q_next = q_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

FILE: hw/rtl/sest_check.sv
// Port-level checker for the scored entry table, bound to its top level.
module sest_check
    import sest_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input sest_out_t out_data
);

    // A result waiting on a stalled consumer holds its value.
    a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // Work on one transaction blocks the input in the cycle after acceptance.
    a_one_at_a_time : assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted while a transaction is in progress");

    // Only the three defined status codes appear.
    a_status_code : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status == STATUS_OK) || (out_data.status == STATUS_RANGE)
                      || (out_data.status == STATUS_FULL))
        else $error("undefined status code");

    // A failed transaction never shows entry contents.
    a_error_zero : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != STATUS_OK)
        |-> (out_data.entry_move == '0) && (out_data.entry_score == '0)
            && (out_data.entry_previous == '0))
        else $error("entry fields set on an error result");

endmodule

bind scored_entry_table_with_stable_sort sest_check u_sest_check (.*);

FILE: dv/scored_entry_table_with_stable_sort_checker.sv
// Checker that predicts and compares every result of the scored entry table.
module scored_entry_table_with_stable_sort_checker
    import sest_pkg::*;
#(
    parameter int DEPTH = 256
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  sest_in_t              in_data,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  sest_out_t             out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic [APB_DATA_W-1:0] prdata,
    input  logic                  pready,
    output int                    mismatches,
    output int                    outstanding,
    output int                    results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [APB_ADDR_W-1:0] INIT_SCORE_ADDR = {REG_INIT_SCORE, 2'b00};

    // Mirror of the table contents and of the initial score register.
    sest_entry_t               rows [DEPTH];
    int unsigned               live_rows = 0;
    logic signed [SCORE_W-1:0] fill_score = INIT_SCORE_RESET;

    sest_out_t expected_results [$];
    int        fail_count = 0;
    int        result_count = 0;
    int        waiting_count = 0;

    assign mismatches   = fail_count;
    assign outstanding  = waiting_count;
    assign results_seen = result_count;

    // Applies one transaction to the mirror and returns the result it must give.
    function automatic sest_out_t apply_action(input sest_in_t req);
        sest_out_t   res;
        sest_entry_t held;
        logic        hit;
        int          slot;
        int          i;
        int          j;
        res  = '0;
        hit  = req.entry_number >= 1 && req.entry_number <= live_rows;
        slot = hit ? int'(req.entry_number) - 1 : 0;
        case (req.action)
            ACT_CLEAR: live_rows = 0;
            ACT_APPEND:
                if (live_rows >= DEPTH)
                    res.status = STATUS_FULL;
                else
                begin
                    rows[live_rows].move  = req.move_word;
                    rows[live_rows].score = fill_score;
                    rows[live_rows].prev  = fill_score;
                    live_rows++;
                end
            ACT_PROMOTE:
                if (!hit)
                    res.status = STATUS_RANGE;
                else
                begin
                    held = rows[slot];
                    for (j = slot; j > 0; j--)
                        rows[j] = rows[j-1];
                    rows[0] = held;
                end
            ACT_SORT:
                // Insertion sort: an entry only passes strictly lower scores,
                // so equal scores keep their order.
                for (i = 1; i < live_rows; i++)
                begin
                    held = rows[i];
                    j    = i;
                    while (j > 0 && rows[j-1].score < held.score)
                    begin
                        rows[j] = rows[j-1];
                        j--;
                    end
                    rows[j] = held;
                end
            ACT_STORE_PREV:
                for (i = 0; i < live_rows; i++)
                    rows[i].prev = rows[i].score;
            ACT_UPDATE:
                if (!hit)
                    res.status = STATUS_RANGE;
                else
                    rows[slot].score = req.new_score;
            ACT_READ:
                if (!hit)
                    res.status = STATUS_RANGE;
                else
                begin
                    res.entry_move     = rows[slot].move;
                    res.entry_score    = rows[slot].score;
                    res.entry_previous = rows[slot].prev;
                end
            default: ;
        endcase
        res.entry_count = NUM_W'(live_rows);
        return res;
    endfunction

    task automatic check_field(input string field, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        sest_out_t want;
        if (!rst_n)
        begin
            live_rows = 0;
            fill_score = INIT_SCORE_RESET;
            expected_results.delete();
            waiting_count = 0;
        end
        else
        begin
            if (psel && penable && pready && paddr == INIT_SCORE_ADDR)
            begin
                if (pwrite)
                    fill_score = pwdata[SCORE_W-1:0];
                else
                    check_field("initial_score", fill_score, $signed(prdata[SCORE_W-1:0]));
            end
            // The output side is handled first: a result taken at this edge
            // always belongs to a transaction accepted at an earlier edge.
            if (out_valid && !out_stall)
            begin
                result_count++;
                if (expected_results.size() == 0)
                begin
                    $error("result with no transaction waiting for it");
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, out_data.status);
                    check_field("entry_move", want.entry_move, out_data.entry_move);
                    check_field("entry_score", want.entry_score, out_data.entry_score);
                    check_field("entry_previous", want.entry_previous,
                                out_data.entry_previous);
                    check_field("entry_count", want.entry_count, out_data.entry_count);
                end
            end
            if (in_valid && !in_stall)
                expected_results.push_back(apply_action(in_data));
            waiting_count = expected_results.size();
        end
    end

endmodule

FILE: dv/scored_entry_table_with_stable_sort_test.sv
// Testbench top for the scored entry table: stimulus, stall patterns and verdict.
module scored_entry_table_with_stable_sort_test;
    import sest_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 256;

    // The action field has one code the block leaves unused; it must be ignored.
    localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;
    localparam logic [APB_ADDR_W-1:0] INIT_SCORE_ADDR = {REG_INIT_SCORE, 2'b00};

    localparam int TARGET_ITEMS = 850;
    // The slowest transaction walks the whole chain; on top of that come the
    // longest output stall and the longest sender gap. The limit takes that
    // several times over.
    localparam int STALL_LIMIT = 8 * (DEPTH + 160);
    localparam int SETTLE_CYCLES = DEPTH + 8;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    sest_in_t              in_data;
    logic                  out_valid;
    logic                  out_stall;
    sest_out_t             out_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int mismatches;
    int outstanding;
    int results_seen;

    // When calm is set, neither side idles, so back-to-back transactions occur.
    bit calm;
    // Number of entries the table holds, tracked only to aim the entry numbers.
    int table_len;
    int items_sent;
    int settings_written;
    int idle_cycles = 0;
    int action_tally [8];

    scored_entry_table_with_stable_sort #(
        .DEPTH(DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    scored_entry_table_with_stable_sort_checker #(
        .DEPTH(DEPTH)
    ) table_monitor (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .results_seen(results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Scores lean toward a few small values so that the sort sees many ties,
    // with the two's complement extremes mixed in.
    function automatic logic [SCORE_W-1:0] pick_score();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            v = int'($urandom_range(0, 4)) - 2;
            return v[SCORE_W-1:0];
        end
        if (r < 65)
        begin
            case ($urandom_range(0, 3))
                0: return 16'h7FFF;
                1: return 16'h8000;
                2: return 16'h8001;
                default: return 16'h0000;
            endcase
        end
        return SCORE_W'($urandom_range(0, 65535));
    endfunction

    function automatic sest_in_t make_item(input logic [ACT_W-1:0] act, input int number,
                                           input int move, input logic [SCORE_W-1:0] score);
        sest_in_t item;
        item.action       = act;
        item.entry_number = number[NUM_W-1:0];
        item.move_word    = move[MOVE_W-1:0];
        item.new_score    = score;
        return item;
    endfunction

    function automatic int good_number();
        return table_len == 0 ? 0 : $urandom_range(1, table_len);
    endfunction

    // Zero or a number past the last entry, up to the largest the field holds.
    function automatic int bad_number();
        return $urandom_range(0, 1) ? 0 : $urandom_range(table_len + 1, 511);
    endfunction

    // One transaction of the random mix: mostly well aimed operations on the
    // live entries, the rest bad entry numbers, the unused code, appends and clears.
    function automatic sest_in_t random_op();
        int r;
        int mv;
        r  = $urandom_range(0, 99);
        mv = $urandom_range(0, 65535);
        if (r < 22)
            return make_item(ACT_UPDATE, good_number(), mv, pick_score());
        if (r < 44)
            return make_item(ACT_READ, good_number(), mv, pick_score());
        if (r < 52)
            return make_item(ACT_SORT, $urandom_range(0, 511), mv, pick_score());
        if (r < 62)
            return make_item(ACT_PROMOTE, good_number(), mv, pick_score());
        if (r < 68)
            return make_item(ACT_STORE_PREV, $urandom_range(0, 511), mv, pick_score());
        if (r < 76)
            return make_item(ACT_APPEND, $urandom_range(0, 511), mv, pick_score());
        if (r < 79)
            return make_item(ACT_PROMOTE, bad_number(), mv, pick_score());
        if (r < 82)
            return make_item(ACT_UPDATE, bad_number(), mv, pick_score());
        if (r < 85)
            return make_item(ACT_READ, bad_number(), mv, pick_score());
        if (r < 90)
            return make_item(ACT_UNUSED, $urandom_range(0, 511), mv, pick_score());
        if (r < 97)
            return make_item(ACT_APPEND, $urandom_range(0, 511), mv, pick_score());
        return make_item(ACT_CLEAR, $urandom_range(0, 511), mv, pick_score());
    endfunction

    // Offers one transaction after a random gap and returns at the falling edge
    // that follows its acceptance. Valid stays high when no gap follows, so a
    // run of transactions streams without a bubble.
    task automatic send_item(input sest_in_t item);
        int gap;
        gap = calm ? 0 : pick_idle();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        action_tally[item.action]++;
        items_sent++;
        if (item.action == ACT_CLEAR)
            table_len = 0;
        else if (item.action == ACT_APPEND && table_len < DEPTH)
            table_len++;
    endtask

    // Holds the sender back until every result in flight has been taken.
    task automatic pause_until_empty();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
    endtask

    // One APB transfer to the initial score register: setup, then access.
    task automatic apb_access(input logic write, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= INIT_SCORE_ADDR;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // The register is only touched with the block idle; every transaction gives
    // a result, so a short settle after the last one is enough. The value is
    // read back right after the write.
    task automatic set_initial_score(input logic [SCORE_W-1:0] value);
        pause_until_empty();
        repeat (8) @(negedge clk);
        apb_access(1'b1, {{(APB_DATA_W-SCORE_W){value[SCORE_W-1]}}, value});
        apb_access(1'b0, '0);
        settings_written++;
    endtask

    // Output side: alternating stretches of taking and stalling, with the odd
    // long stall. In calm stretches results are taken as soon as they appear.
    initial
    begin : result_taker
        bit stall_value;
        int hold;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (calm || $urandom_range(0, 1))
            begin
                stall_value = 1'b0;
                hold        = $urandom_range(1, 8);
            end
            else
            begin
                stall_value = 1'b1;
                hold        = 1 + pick_idle();
            end
            out_stall <= stall_value;
            repeat (hold) @(negedge clk);
        end
    end

    // Watchdog: too many cycles in a row without any transaction on either
    // channel or on the register port means the block has hung.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (psel && penable))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int  count;
        int  step;
        int  num;
        bit  filled;
        logic [SCORE_W-1:0] setting;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        calm        = 1'b0;
        table_len   = 0;
        items_sent  = 0;
        settings_written = 0;
        filled      = 1'b0;
        step        = 0;
        foreach (action_tally[i])
            action_tally[i] = 0;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The register must come out of reset at its documented value.
        apb_access(1'b0, '0);

        // Directed part. On the empty table every numbered operation is out of
        // range, and sort, store-previous and the unused code do nothing.
        send_item(make_item(ACT_READ, 1, 16'h0000, 16'h0000));
        send_item(make_item(ACT_PROMOTE, 0, 16'hFFFF, 16'hFFFF));
        send_item(make_item(ACT_UPDATE, 511, 16'hFFFF, 16'h7FFF));
        send_item(make_item(ACT_SORT, 0, 16'h0000, 16'h8000));
        send_item(make_item(ACT_STORE_PREV, 0, 16'h0000, 16'h0000));
        send_item(make_item(ACT_UNUSED, 511, 16'hFFFF, 16'hFFFF));
        // Four entries, all taking the reset initial score.
        send_item(make_item(ACT_APPEND, 0, 16'hFFFF, 16'h0000));
        send_item(make_item(ACT_APPEND, 0, 16'h0000, 16'h0000));
        send_item(make_item(ACT_APPEND, 0, 16'h5A5A, 16'h0000));
        send_item(make_item(ACT_APPEND, 0, 16'hA5A5, 16'h0000));
        // Score extremes, including the pattern below the stated range.
        send_item(make_item(ACT_UPDATE, 2, 0, 16'h7FFF));
        send_item(make_item(ACT_UPDATE, 4, 0, 16'h8000));
        // Entry numbers just outside the table on both sides.
        send_item(make_item(ACT_READ, 0, 0, 16'h0000));
        send_item(make_item(ACT_READ, 5, 0, 16'h0000));
        send_item(make_item(ACT_STORE_PREV, 0, 0, 16'h0000));
        send_item(make_item(ACT_UPDATE, 1, 0, 16'h8001));
        // Entries two and three tie at the top; the sort must keep them in order.
        send_item(make_item(ACT_UPDATE, 3, 0, 16'h7FFF));
        send_item(make_item(ACT_SORT, 0, 0, 16'h0000));
        // Promoting the first entry moves nothing; promoting the last one
        // shifts all the others down.
        send_item(make_item(ACT_PROMOTE, 1, 0, 16'h0000));
        send_item(make_item(ACT_PROMOTE, 4, 0, 16'h0000));
        for (num = 1; num <= 4; num++)
            send_item(make_item(ACT_READ, num, 0, 16'h0000));
        send_item(make_item(ACT_CLEAR, 0, 0, 16'h0000));
        send_item(make_item(ACT_READ, 1, 0, 16'h0000));

        set_initial_score(16'h7FFF);

        // Random part, in short sequences: usually a fresh table filled with a
        // few entries and then worked on by a random mix of operations.
        while (items_sent < TARGET_ITEMS)
        begin
            step++;
            // Every few sequences the initial score moves on to the next
            // setting, so both ends of its range and the pattern below it are
            // used as appended scores.
            if (step % 4 == 0)
            begin
                case ((step / 4) % 5)
                    0: setting = 16'h8001;
                    1: setting = 16'h0000;
                    2: setting = 16'h8000;
                    3: setting = SCORE_W'($urandom_range(0, 65535));
                    default: setting = 16'h7FFF;
                endcase
                set_initial_score(setting);
            end
            calm = ($urandom_range(0, 4) == 0);

            if (!filled && items_sent >= 350)
            begin
                // Fill the whole table and push two more appends past its end,
                // then scramble the scores and sort all DEPTH entries.
                filled = 1'b1;
                send_item(make_item(ACT_CLEAR, 0, $urandom_range(0, 65535), pick_score()));
                repeat (DEPTH + 2)
                    send_item(make_item(ACT_APPEND, $urandom_range(0, 511),
                                        $urandom_range(0, 65535), pick_score()));
                repeat (24)
                    send_item(make_item(ACT_UPDATE, good_number(), 0, pick_score()));
                send_item(make_item(ACT_STORE_PREV, 0, 0, 16'h0000));
                repeat (8)
                    send_item(make_item(ACT_UPDATE, good_number(), 0, pick_score()));
                send_item(make_item(ACT_SORT, 0, 0, 16'h0000));
                send_item(make_item(ACT_READ, 1, 0, 16'h0000));
                send_item(make_item(ACT_READ, DEPTH, 0, 16'h0000));
                repeat (4)
                    send_item(make_item(ACT_READ, good_number(), 0, 16'h0000));
                send_item(make_item(ACT_PROMOTE, DEPTH, 0, 16'h0000));
                send_item(make_item(ACT_READ, 1, 0, 16'h0000));
                send_item(make_item(ACT_PROMOTE, 1, 0, 16'h0000));
                send_item(make_item(ACT_READ, DEPTH + 1, 0, 16'h0000));
                send_item(make_item(ACT_UPDATE, 511, 0, 16'h7FFF));
            end
            else
            begin
                if (table_len == 0 || $urandom_range(0, 3) != 0)
                begin
                    send_item(make_item(ACT_CLEAR, $urandom_range(0, 511),
                                        $urandom_range(0, 65535), pick_score()));
                    count = $urandom_range(1, 12);
                    repeat (count)
                        send_item(make_item(ACT_APPEND, $urandom_range(0, 511),
                                            $urandom_range(0, 65535), pick_score()));
                end
                count = $urandom_range(6, 18);
                repeat (count)
                    send_item(random_op());
                // Sometimes read the whole table back to see every entry's place.
                if (table_len <= 12 && $urandom_range(0, 2) == 0)
                    for (num = 1; num <= table_len; num++)
                        send_item(make_item(ACT_READ, num, $urandom_range(0, 65535),
                                            pick_score()));
            end

            if ($urandom_range(0, 4) == 0)
                pause_until_empty();
        end

        // Drain, then give the block a full walk of the chain to show any
        // stray result.
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Run covered %0d transactions: %0d clear, %0d append, %0d promote, %0d sort,",
                 items_sent, action_tally[ACT_CLEAR], action_tally[ACT_APPEND],
                 action_tally[ACT_PROMOTE], action_tally[ACT_SORT]);
        $display(
            "%0d store-previous, %0d update, %0d read, %0d unused; %0d results, %0d settings.",
            action_tally[ACT_STORE_PREV], action_tally[ACT_UPDATE],
            action_tally[ACT_READ], action_tally[ACT_UNUSED], results_seen,
            settings_written);
        if (mismatches == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/sest_pkg.sv
hw/rtl/sest_cell.sv
hw/rtl/scored_entry_table_with_stable_sort.sv
hw/rtl/sest_check.sv
dv/scored_entry_table_with_stable_sort_checker.sv
dv/scored_entry_table_with_stable_sort_test.sv
